// ----- rtl/status_pixel_pattern_ws2812_encoder_defines.svh -----
// Assertion macros for the status pixel encoder RTL.
`ifndef STATUS_PIXEL_PATTERN_WS2812_ENCODER_DEFINES_SVH
`define STATUS_PIXEL_PATTERN_WS2812_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPPWE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("status pixel encoder check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SPPWE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("status pixel encoder check failed");

`endif

// ----- rtl/sppwe_pkg.sv -----
// Types, constants and register map of the status pixel encoder.
package sppwe_pkg;

	localparam int PIXELS_DEF     = 1;
	localparam int FIFO_DEPTH_DEF = 2;
	localparam int BITS_PER_PIXEL = 24;

	localparam logic [7:0] SYM_ONE  = 8'hF8;
	localparam logic [7:0] SYM_ZERO = 8'hC0;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_COOL  = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;
	localparam logic [2:0] ST_FAULT = 3'd4;

	localparam logic       REG_LOW_BATT = 1'b0;
	localparam logic       REG_BOOT     = 1'b1;
	localparam logic [6:0] LOW_BATT_RST = 7'd20;
	localparam logic [15:0] BOOT_RST    = 16'd3000;

	// floor(2^37 / 125) and floor(2^38 / 375) for the time dividers.
	localparam logic [30:0] RECIP_125 = 31'd1099511627;
	localparam logic [29:0] RECIP_375 = 30'd733007751;
	// ceil(2^19 / 75), exact for the breathe ramp range.
	localparam logic [12:0] RECIP_75  = 13'd6991;

	typedef struct packed {
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] b;
	} color_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- rtl/sppwe_front.sv -----
// Front end: accepts status requests, derives the colour, drops repeats.
module sppwe_front
	import sppwe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [6:0]  low_battery_percent,
	input  logic [15:0] boot_time_ms,
	input  fifo_stat_t  fifo_stat,
	output logic        push,
	output color_t      push_color
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [31:0] ms_s1, ms_s2;
	logic [2:0]  st_s1, st_s2, st_s3, st_s4;
	logic [6:0]  batt_s1, batt_s2, batt_s3, batt_s4;
	logic [3:0]  flags_s1, flags_s2, flags_s3, flags_s4;
	logic [23:0] q5_s2;
	logic [20:0] q3_s2;
	logic        blink1_s3, blink2_s3, boot_s3;
	logic        blink1_s4, blink2_s4, boot_s4;
	logic [10:0] t_s3;
	logic [6:0]  v_lvl_s4;
	color_t      shown_q;

	logic [60:0] p5;
	logic [58:0] p3;
	logic [29:0] d5;
	logic [28:0] d3;
	logic [7:0]  r5raw;
	logic [6:0]  r5;
	logic        q5lsb;
	logic [9:0]  r3raw;
	logic [8:0]  r3;
	logic [8:0]  m500;
	logic [11:0] p3000;
	logic [10:0] t_c;
	logic [25:0] bprod;
	color_t      col;
	logic        changed;

	assign changed       = (col != shown_q);
	assign adv           = !(v_s4 && changed && fifo_stat.full);
	assign s_axis_tready = adv;
	assign push          = v_s4 && changed && !fifo_stat.full;
	assign push_color    = col;

	// Quotients by 500 and 3000 through reciprocal multiplies, low by at most one.
	assign p5 = {31'b0, ms_s1[31:2]} * {30'b0, RECIP_125};
	assign p3 = {30'b0, ms_s1[31:3]} * {29'b0, RECIP_375};

	always_comb begin
		d5    = ms_s2[31:2] - ({6'b0, q5_s2} * 30'd125);
		r5raw = d5[7:0];
		if (r5raw >= 8'd125) begin
			r5    = 7'(r5raw - 8'd125);
			q5lsb = ~q5_s2[0];
		end else begin
			r5    = r5raw[6:0];
			q5lsb = q5_s2[0];
		end
		m500 = {r5, ms_s2[1:0]};

		d3    = ms_s2[31:3] - ({8'b0, q3_s2} * 29'd375);
		r3raw = d3[9:0];
		if (r3raw >= 10'd375) begin
			r3 = 9'(r3raw - 10'd375);
		end else begin
			r3 = r3raw[8:0];
		end
		p3000 = {r3, ms_s2[2:0]};
		if (p3000 < 12'd1500) begin
			t_c = p3000[10:0];
		end else begin
			t_c = 11'(12'd3000 - p3000);
		end
	end

	assign bprod = {13'b0, t_s3, 2'b00} * {13'b0, RECIP_75};

	always_comb begin
		col = '0;
		if (boot_s4) begin
			col.b = 8'd60;
		end else begin
			unique case (st_s4)
				ST_FAULT: begin
					if (blink2_s4) col.r = 8'd120;
				end
				ST_DONE: begin
					col.g = 8'd120;
				end
				ST_COOL: begin
					if (blink1_s4) begin
						col.g = 8'd60;
						col.b = 8'd60;
					end
				end
				ST_RUN: begin
					if (batt_s4 < low_battery_percent) begin
						if (blink1_s4) begin
							col.g = 8'd60;
							col.r = 8'd120;
						end
					end else if (flags_s4[0]) begin
						if (blink1_s4) begin
							col.g = 8'd80;
							col.r = 8'd80;
						end
					end else if (flags_s4[1]) begin
						if (blink1_s4) begin
							col.g = 8'd40;
							col.r = 8'd100;
						end
					end else begin
						col.g = {1'b0, v_lvl_s4};
					end
				end
				default: begin
					// Idle and the unused state codes.
					if (flags_s4[2] && !flags_s4[3]) begin
						col.g = 8'd60;
						col.r = 8'd120;
					end else begin
						col.g = {3'b0, v_lvl_s4[6:2]};
						col.b = {3'b0, v_lvl_s4[6:2]};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			shown_q <= '{g: 8'hFF, r: 8'hFF, b: 8'hFF};
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) shown_q <= col;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ms_s1     <= s_axis_tdata[31:0];
			st_s1     <= s_axis_tdata[34:32];
			batt_s1   <= s_axis_tdata[41:35];
			flags_s1  <= s_axis_tdata[45:42];

			ms_s2     <= ms_s1;
			st_s2     <= st_s1;
			batt_s2   <= batt_s1;
			flags_s2  <= flags_s1;
			q5_s2     <= p5[60:37];
			q3_s2     <= p3[58:38];

			st_s3     <= st_s2;
			batt_s3   <= batt_s2;
			flags_s3  <= flags_s2;
			blink1_s3 <= q5lsb;
			blink2_s3 <= (m500 >= 9'd250);
			boot_s3   <= (ms_s2 < {16'b0, boot_time_ms});
			t_s3      <= t_c;

			st_s4     <= st_s3;
			batt_s4   <= batt_s3;
			flags_s4  <= flags_s3;
			blink1_s4 <= blink1_s3;
			blink2_s4 <= blink2_s3;
			boot_s4   <= boot_s3;
			v_lvl_s4  <= 7'd20 + bprod[25:19];
		end
	end

endmodule

// ----- rtl/sppwe_fifo.sv -----
// Small register queue of colours between the front end and the serializer.
module sppwe_fifo
	import sppwe_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  color_t     push_color,
	input  logic       pop,
	output color_t     pop_color,
	output fifo_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	color_t        mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_color  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_color;
	end

endmodule

// ----- rtl/sppwe_back.sv -----
// Serializer: turns each queued colour into WS2812 SPI symbol bytes.
module sppwe_back
	import sppwe_pkg::*;
#(
	parameter int PIXELS = PIXELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  color_t     fifo_color,
	input  fifo_stat_t fifo_stat,
	output logic       pop,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,
	output logic       m_axis_tlast
);

	localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	logic             busy_q;
	logic [4:0]       bit_q;
	logic [PIX_W-1:0] pix_q;
	logic [23:0]      sh_q;
	color_t           color_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	logic adv, last_bit, last;

	assign adv      = !m_tvalid_q || m_axis_tready;
	assign last_bit = (bit_q == 5'(BITS_PER_PIXEL - 1));
	assign last     = last_bit && (pix_q == PIX_W'(PIXELS - 1));
	assign pop      = !fifo_stat.empty && (!busy_q || (adv && last));

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			bit_q      <= '0;
			pix_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) m_tvalid_q <= busy_q;
			if (pop) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				pix_q  <= '0;
			end else if (adv && busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else if (last_bit) begin
					bit_q <= '0;
					pix_q <= pix_q + 1'b1;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			m_tdata_q <= sh_q[23] ? SYM_ONE : SYM_ZERO;
			m_tlast_q <= last;
		end
		if (pop) begin
			color_q <= fifo_color;
			sh_q    <= fifo_color;
		end else if (adv && busy_q) begin
			// Every pixel repeats the same colour, so reload at a pixel boundary.
			sh_q <= last_bit ? color_q : {sh_q[22:0], 1'b0};
		end
	end

endmodule

// ----- rtl/status_pixel_pattern_ws2812_encoder.sv -----
// Top level of the status pixel colour selector and WS2812 SPI encoder.
// Each request on the input stream carries the millisecond time and the machine
// status; the front end derives a GRB colour in a four-stage pipeline and drops requests
// whose colour equals the one last sent, at one request per cycle unless a changed colour
// waits on a full queue. A changed colour goes into a queue of FIFO_DEPTH entries (two by
// default), and the serializer turns it into 24*PIXELS SPI symbol bytes (0xF8 for a one bit,
// 0xC0 for a zero bit, green, red, blue, MSB first), one byte per cycle while m_axis_tready
// holds, with tlast on the final byte; it takes the next queued colour as it sends that byte.
// The serializer therefore sets the sustained rate of changed colours. Registers:
// low_battery_percent at address 0, boot_time_ms at address 4.
`include "status_pixel_pattern_ws2812_encoder_defines.svh"

module status_pixel_pattern_ws2812_encoder
	import sppwe_pkg::*;
#(
	parameter int PIXELS     = PIXELS_DEF,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// time_ms[31:0], machine_state[34:32], battery_level[41:35],
	// warning_active[42], boost_active[43], door_present[44], door_shut[45]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// spi_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0]  low_batt_q;
	logic [15:0] boot_q;
	logic        fifo_push, fifo_pop;
	color_t      push_color, pop_color;
	fifo_stat_t  fifo_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_batt_q <= LOW_BATT_RST;
			boot_q     <= BOOT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_LOW_BATT: low_batt_q <= pwdata[6:0];
				REG_BOOT:     boot_q     <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LOW_BATT: prdata = {25'b0, low_batt_q};
			REG_BOOT:     prdata = {16'b0, boot_q};
			default:      prdata = '0;
		endcase
	end

	sppwe_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.low_battery_percent (low_batt_q),
		.boot_time_ms        (boot_q),
		.fifo_stat           (fifo_stat),
		.push                (fifo_push),
		.push_color          (push_color)
	);

	sppwe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fifo_push),
		.push_color (push_color),
		.pop        (fifo_pop),
		.pop_color  (pop_color),
		.stat       (fifo_stat)
	);

	sppwe_back #(
		.PIXELS (PIXELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_color    (pop_color),
		.fifo_stat     (fifo_stat),
		.pop           (fifo_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// The front end only stalls on a full queue.
	`SPPWE_ASSERT_IMP(a_stall_only_full, clk, arst_n, !s_axis_tready, fifo_stat.full)
	`SPPWE_ASSERT_IMP(a_no_push_full, clk, arst_n, fifo_push, !fifo_stat.full)
	`SPPWE_ASSERT_IMP(a_symbol_legal, clk, arst_n, m_axis_tvalid, (m_axis_tdata == SYM_ONE || m_axis_tdata == SYM_ZERO))
	// Bytes of one frame follow each other without gaps.
	`SPPWE_ASSERT_NXT(a_frame_gapless, clk, arst_n, (m_axis_tvalid && m_axis_tready && !m_axis_tlast), m_axis_tvalid)

endmodule
